// ===== hw/rtl/ssad_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ssad_pkg;

    // Field widths
    localparam int LEVEL_W = 8;
    localparam int THR_W   = 8;
    localparam int CNT_W   = 4;

    // Averaging period, in periodic samples
    localparam int AVG_PERIOD = 10;

    // Register reset values
    localparam logic [THR_W-1:0]          THRESHOLD_RST     = 8'd3;
    localparam logic signed [LEVEL_W-1:0] DEFAULT_LEVEL_RST = -8'sd128;

    // Item kinds carried on tuser
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_INIT   = 1'b1;

    // Register select, taken from paddr[2]
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_DEFAULT   = 1'b1;

    // Per-item control that rides along the averaging pipeline
    typedef struct packed {
        logic init;     // init fill item
        logic invalid;  // periodic sample that is not negative
        logic avg_en;   // an average is taken for this item
        logic normal;   // normal working mode
    } t_side;

endpackage

`default_nettype wire

// ===== hw/rtl/signal_strength_average_deadband_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake                 Payload
// s stream  in   i_s_tvalid / o_s_tready   tdata: sample[7:0], normal_mode[8]; tuser: action
// m stream  out  o_m_tvalid / i_m_tready   tdata: reported_level[7:0], average_level[15:8],
//                                          published[16]
// apb       in   psel, penable, pwrite     0x0 change_threshold, 0x4 default_level
//
// One item per cycle sustained while the output is not stalled. The accepting edge
// updates the history chain and loads the first of three averaging stages, the last
// of which feeds the output register holding the level.
// Synchronous active-low reset clears history, sum and count; level resets to -128.
// Each stage holds only while the stage after it is full and stalled, so items
// keep entering while a finished result waits on the output.
module signal_strength_average_deadband_core
    import ssad_pkg::*;
#(
    parameter int HISTORY_DEPTH = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // sample[7:0], normal_mode[8], zero pad
    input  wire logic        i_s_tuser,   // action

    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,   // reported_level[7:0], average_level[15:8],
                                          // published[16], zero pad

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int SUM_W = $clog2(128 * HISTORY_DEPTH + 1) + 1;
    localparam logic signed [SUM_W-1:0] DEPTH_S = SUM_W'(HISTORY_DEPTH);

    // Configuration registers
    logic [THR_W-1:0]          r_threshold;
    logic signed [LEVEL_W-1:0] r_default;
    logic                      cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_default   <= DEFAULT_LEVEL_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_THRESHOLD: r_threshold <= pwdata[THR_W-1:0];
                REG_DEFAULT:   r_default   <= $signed(pwdata[LEVEL_W-1:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_THRESHOLD: prdata = 32'(r_threshold);
            REG_DEFAULT:   prdata = 32'($unsigned(r_default));
            default:       prdata = '0;
        endcase
    end

    // Input decode
    logic                      in_acc;
    logic                      act;
    logic signed [LEVEL_W-1:0] sample;
    logic                      normal;
    logic                      sample_ok;

    assign act       = i_s_tuser;
    assign sample    = $signed(i_s_tdata[LEVEL_W-1:0]);
    assign normal    = i_s_tdata[LEVEL_W];
    assign sample_ok = sample[LEVEL_W-1];
    assign in_acc    = i_s_tvalid && o_s_tready;

    // Chain control
    logic                      do_load;
    logic                      do_shift;
    logic signed [LEVEL_W-1:0] fill;

    assign do_load  = in_acc && (act == ACT_INIT);
    assign do_shift = in_acc && (act == ACT_SAMPLE) && sample_ok;
    assign fill     = sample_ok ? sample : r_default;

    // History chain, newest entry in cell 0
    logic signed [LEVEL_W-1:0] hist [HISTORY_DEPTH];

    for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
        logic signed [LEVEL_W-1:0] prev;
        if (g == 0) begin : g_head
            assign prev = sample;
        end else begin : g_body
            assign prev = hist[g-1];
        end
        ssad_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (do_shift),
            .i_load  (do_load),
            .i_fill  (fill),
            .i_prev  (prev),
            .o_value (hist[g])
        );
    end

    // Running sum of the chain and sample counter
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] n_sum;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;

    always_comb begin
        n_count = (r_count == CNT_W'(AVG_PERIOD - 1)) ? '0 : r_count + 1'b1;
        n_sum   = r_sum;
        if (act == ACT_INIT) begin
            n_sum = SUM_W'(fill) * DEPTH_S;
        end else if (sample_ok) begin
            n_sum = r_sum + SUM_W'(sample) - SUM_W'(hist[HISTORY_DEPTH-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
        end else if (in_acc) begin
            r_sum <= n_sum;
            if (act == ACT_SAMPLE) begin
                r_count <= n_count;
            end
        end
    end

    // Item control into the averaging pipeline
    t_side side_in;

    always_comb begin
        side_in.init    = (act == ACT_INIT);
        side_in.invalid = (act == ACT_SAMPLE) && !sample_ok;
        side_in.avg_en  = (act == ACT_INIT) || (sample_ok && (n_count == '0));
        side_in.normal  = normal;
    end

    logic                      avg_valid;
    logic                      avg_ready;
    logic signed [LEVEL_W-1:0] avg;
    t_side                     avg_side;

    ssad_avg #(
        .DEPTH (HISTORY_DEPTH)
    ) u_avg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_sum   (n_sum),
        .i_side  (side_in),
        .o_valid (avg_valid),
        .i_ready (avg_ready),
        .o_avg   (avg),
        .o_side  (avg_side)
    );

    // Deadband decision and output register
    logic signed [LEVEL_W-1:0] r_level;
    logic signed [LEVEL_W-1:0] n_level;
    logic signed [LEVEL_W-1:0] n_avg_out;
    logic                      n_pub;
    logic signed [LEVEL_W+1:0] diff;
    logic [LEVEL_W+1:0]        diff_abs;
    logic                      r_ov;
    logic signed [LEVEL_W-1:0] r_out_level;
    logic signed [LEVEL_W-1:0] r_out_avg;
    logic                      r_out_pub;
    logic                      out_take;

    assign avg_ready = !r_ov || i_m_tready;
    assign out_take  = avg_valid && avg_ready;

    assign diff     = (LEVEL_W + 2)'(r_level) - (LEVEL_W + 2)'(avg);
    assign diff_abs = diff[LEVEL_W+1] ? $unsigned(-diff) : $unsigned(diff);

    always_comb begin
        n_level   = r_level;
        n_avg_out = r_level;
        n_pub     = 1'b0;
        if (avg_side.init) begin
            n_level   = avg;
            n_avg_out = avg;
            n_pub     = 1'b1;
        end else if (avg_side.invalid) begin
            n_level = '0;
        end else if (avg_side.avg_en) begin
            n_avg_out = avg;
            if (diff_abs >= (LEVEL_W + 2)'(r_threshold)) begin
                n_level = avg;
                n_pub   = (avg != '0) && avg_side.normal;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov    <= 1'b0;
            r_level <= DEFAULT_LEVEL_RST;
        end else if (avg_ready) begin
            r_ov <= avg_valid;
            if (avg_valid) begin
                r_level <= n_level;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take) begin
            r_out_level <= n_level;
            r_out_avg   <= n_avg_out;
            r_out_pub   <= n_pub;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {7'd0, r_out_pub, r_out_avg, r_out_level};

endmodule

`default_nettype wire

// ===== hw/rtl/ssad_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One history entry: shifts from its neighbor or loads the init fill
module ssad_cell
    import ssad_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_shift,
    input  wire logic                      i_load,
    input  wire logic signed [LEVEL_W-1:0] i_fill,
    input  wire logic signed [LEVEL_W-1:0] i_prev,
    output logic signed [LEVEL_W-1:0]      o_value
);

    logic signed [LEVEL_W-1:0] r_value;
    logic signed [LEVEL_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        if (i_load) begin
            n_value = i_fill;
        end else if (i_shift) begin
            n_value = i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
        end else begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

// ===== hw/rtl/ssad_avg.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Rounded average of the history sum: trunc((2*sum + D) / (2*D)).
// Three stages: magnitude of the numerator, reciprocal multiply, sign.
// The reciprocal is rounded up and wide enough to be exact for every
// numerator magnitude that can occur, so no correction step is needed.
module ssad_avg
    import ssad_pkg::*;
#(
    parameter int DEPTH = 10,
    localparam int SUM_W = $clog2(128 * DEPTH + 1) + 1
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic signed [SUM_W-1:0] i_sum,
    input  wire t_side                   i_side,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic signed [LEVEL_W-1:0]    o_avg,
    output t_side                        o_side
);

    localparam int NUM_W       = SUM_W + 2;
    localparam int ABS_W       = $clog2(255 * DEPTH + 1);
    localparam int DIV         = 2 * DEPTH;
    localparam int RCP_SHIFT   = ABS_W + $clog2(DIV);
    localparam int MUL_W       = ABS_W + 1;
    localparam int PROD_W      = ABS_W + MUL_W + LEVEL_W;
    localparam longint RCP_MULT = ((longint'(1) <<< RCP_SHIFT) + DIV - 1) / DIV;
    localparam logic signed [NUM_W-1:0] DEPTH_N = NUM_W'(DEPTH);

    // Stage valids and ready chain
    logic r_va, r_vb, r_vc;
    logic rdy_a, rdy_b, rdy_c;

    assign rdy_c   = !r_vc || i_ready;
    assign rdy_b   = !r_vb || rdy_c;
    assign rdy_a   = !r_va || rdy_b;
    assign o_ready = rdy_a;

    // Stage A: numerator and its magnitude
    logic signed [NUM_W-1:0] w_sum_ext;
    logic signed [NUM_W-1:0] w_num;
    logic signed [NUM_W-1:0] w_abs;
    logic [ABS_W-1:0]        r_abs;
    logic                    r_neg_a;
    t_side                   r_side_a;

    assign w_sum_ext = NUM_W'(i_sum);
    assign w_num     = (w_sum_ext <<< 1) + DEPTH_N;
    assign w_abs     = w_num[NUM_W-1] ? -w_num : w_num;

    // Stage B: quotient by reciprocal multiply
    logic [PROD_W-1:0]  w_prod;
    logic [LEVEL_W-1:0] r_quot;
    logic               r_neg_b;
    t_side              r_side_b;

    assign w_prod = PROD_W'(r_abs) * PROD_W'(RCP_MULT);

    // Stage C: restore sign
    logic signed [LEVEL_W-1:0] r_avg;
    t_side                     r_side_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (rdy_a) begin
                r_va <= i_valid;
            end
            if (rdy_b) begin
                r_vb <= r_va;
            end
            if (rdy_c) begin
                r_vc <= r_vb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a) begin
            r_abs    <= w_abs[ABS_W-1:0];
            r_neg_a  <= w_num[NUM_W-1];
            r_side_a <= i_side;
        end
        if (rdy_b) begin
            r_quot   <= w_prod[RCP_SHIFT +: LEVEL_W];
            r_neg_b  <= r_neg_a;
            r_side_b <= r_side_a;
        end
        if (rdy_c) begin
            r_avg    <= r_neg_b ? -$signed(r_quot) : $signed(r_quot);
            r_side_c <= r_side_b;
        end
    end

    assign o_valid = r_vc;
    assign o_avg   = r_avg;
    assign o_side  = r_side_c;

endmodule

`default_nettype wire

// ===== sim/ssad_level_checker.sv =====
`timescale 1ns / 1ps

// Watches the sample stream, the level stream and the register port, keeps its
// own copy of the averaging state and checks every level item in order.
module ssad_level_checker
    import ssad_pkg::*;
#(
    parameter int HIST_DEPTH = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [15:0] i_s_tdata,   // sample[7:0], normal_mode[8], zero pad
    input  wire logic        i_s_tuser,   // action

    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [23:0] i_m_tdata,   // reported_level[7:0], average_level[15:8],
                                          // published[16], zero pad

    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic        i_pready,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,

    output int               o_errors,
    output int               o_outstanding
);

    typedef struct packed {
        logic signed [LEVEL_W-1:0] reported;
        logic signed [LEVEL_W-1:0] average;
        logic                      published;
    } t_level_item;

    // Shadow state of the averager
    logic signed [LEVEL_W-1:0] hist_q [HIST_DEPTH];
    logic signed [LEVEL_W-1:0] level_q;
    logic        [CNT_W-1:0]   count_q;
    logic        [THR_W-1:0]   thr_q;
    logic signed [LEVEL_W-1:0] dflt_q;

    t_level_item expected_levels [$];
    int          errors = 0;
    int          outstanding = 0;

    assign o_errors      = errors;
    assign o_outstanding = outstanding;

    // Mean plus one half, truncated toward zero
    function automatic logic signed [LEVEL_W-1:0] history_mean();
        int sum;
        sum = 0;
        for (int i = 0; i < HIST_DEPTH; i++) begin
            sum += int'(hist_q[i]);
        end
        return LEVEL_W'((2 * sum + HIST_DEPTH) / (2 * HIST_DEPTH));
    endfunction

    // Advance the shadow state by one accepted item, return the level item it causes
    function automatic t_level_item step_levels(logic act, logic signed [LEVEL_W-1:0] smp,
                                                logic norm);
        t_level_item               res;
        logic signed [LEVEL_W-1:0] fill;
        logic signed [LEVEL_W-1:0] avg;
        int                        diff;
        res.average   = level_q;
        res.published = 1'b0;
        if (act == ACT_INIT) begin
            fill = (smp < 0) ? smp : dflt_q;
            for (int i = 0; i < HIST_DEPTH; i++) begin
                hist_q[i] = fill;
            end
            avg           = history_mean();
            level_q       = avg;
            res.average   = avg;
            res.published = 1'b1;
        end else begin
            count_q = (count_q == CNT_W'(AVG_PERIOD - 1)) ? '0 : count_q + 1'b1;
            if (smp < 0) begin
                for (int i = HIST_DEPTH - 1; i >= 1; i--) begin
                    hist_q[i] = hist_q[i-1];
                end
                hist_q[0] = smp;
                if (count_q == '0) begin
                    avg         = history_mean();
                    res.average = avg;
                    diff        = int'(level_q) - int'(avg);
                    if (diff < 0) begin
                        diff = -diff;
                    end
                    if (diff >= int'(thr_q)) begin
                        level_q       = avg;
                        res.published = (avg != 0) && norm;
                    end
                end
            end else begin
                // invalid sample drops the reported level to no signal
                level_q = '0;
            end
        end
        res.reported = level_q;
        return res;
    endfunction

    task automatic compare_field(string name, int exp_val, int got_val);
        if (exp_val != got_val) begin
            if (errors < 100) begin
                $error("%s mismatch: expected %0d, got %0d", name, exp_val, got_val);
            end
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_level_item exp_item;
        t_level_item got_item;
        if (!i_rst_n) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
                hist_q[i] = '0;
            end
            thr_q   = THRESHOLD_RST;
            dflt_q  = DEFAULT_LEVEL_RST;
            level_q = DEFAULT_LEVEL_RST;
            count_q = '0;
            expected_levels.delete();
            outstanding <= 0;
        end else begin
            // register writes
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_THRESHOLD) begin
                    thr_q = i_pwdata[THR_W-1:0];
                end else begin
                    dflt_q = i_pwdata[LEVEL_W-1:0];
                end
            end

            // accepted sample item
            if (i_s_tvalid && i_s_tready) begin
                expected_levels.push_back(step_levels(i_s_tuser, i_s_tdata[7:0],
                                                      i_s_tdata[8]));
            end

            // accepted level item
            if (i_m_tvalid && i_m_tready) begin
                got_item.reported  = i_m_tdata[7:0];
                got_item.average   = i_m_tdata[15:8];
                got_item.published = i_m_tdata[16];
                if (expected_levels.size() == 0) begin
                    $error("level item with none expected: tdata %h", i_m_tdata);
                    errors++;
                end else begin
                    exp_item = expected_levels.pop_front();
                    compare_field("reported_level", int'(exp_item.reported),
                                  int'(got_item.reported));
                    compare_field("average_level", int'(exp_item.average),
                                  int'(got_item.average));
                    compare_field("published", int'(exp_item.published),
                                  int'(got_item.published));
                end
            end
            outstanding <= expected_levels.size();
        end
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import ssad_pkg::*;

    localparam int HIST_DEPTH   = 10;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 144;
    localparam int SETTLE_TICKS = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tuser = ACT_SAMPLE;

    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [23:0] m_tdata;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire  [31:0] prdata;
    wire         pready;

    int          errors;
    int          outstanding;

    // Idle controls, in percent of cycles
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;

    // Random walk of the signal level
    int          base_level = -60;
    int          jitter = 3;

    signal_strength_average_deadband_core #(
        .HISTORY_DEPTH (HIST_DEPTH)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    ssad_level_checker #(
        .HIST_DEPTH (HIST_DEPTH)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_errors      (errors),
        .o_outstanding (outstanding)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic apb_write(input logic reg_sel, input logic [THR_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        // upper data bits carry junk, only the low byte is kept
        pwdata  <= ($urandom() & 32'hFFFF_FF00) | 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_item(input logic act, input logic signed [7:0] smp, input logic norm);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, norm, smp};
        s_tuser  <= act;
        do @(posedge i_clk); while (!s_tready);
    endtask

    // Wait until every level item is out and the pipeline has settled
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    // Mostly valid samples around a drifting level, some invalid ones and inits
    task automatic send_random_item();
        int   r;
        int   v;
        logic norm;
        r    = $urandom_range(99);
        norm = ($urandom_range(99) < 85);
        if ($urandom_range(99) < 4) begin
            base_level = -int'($urandom_range(128, 1));
            jitter     = $urandom_range(10);
        end
        if (r < 4) begin
            if (r < 2) begin
                send_item(ACT_INIT, 8'($urandom_range(255)), norm);
            end else begin
                send_item(ACT_INIT, 8'(base_level), norm);
            end
        end else if (r < 12) begin
            send_item(ACT_SAMPLE, 8'($urandom_range(127)), norm);
        end else begin
            v = base_level + int'($urandom_range(2 * jitter)) - jitter;
            if (v < -128) begin
                v = -128;
            end
            if (v > -1) begin
                v = -1;
            end
            send_item(ACT_SAMPLE, 8'(v), norm);
        end
    endtask

    initial begin
        logic [THR_W-1:0]   thr;
        logic [LEVEL_W-1:0] dflt;
        logic signed [7:0]  smp;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset level, init fills, invalid samples, extremes
        send_item(ACT_SAMPLE, -8'sd5, 1'b1);
        send_item(ACT_INIT, -8'sd128, 1'b0);
        send_item(ACT_INIT, 8'sd0, 1'b0);
        send_item(ACT_INIT, 8'sd127, 1'b1);
        send_item(ACT_INIT, -8'sd1, 1'b1);
        for (int i = 0; i < 19; i++) begin
            if (i % 7 == 3) begin
                smp = 8'sd0;
            end else if (i % 7 == 5) begin
                smp = 8'sd127;
            end else if (i < 9) begin
                smp = -8'sd128;
            end else begin
                smp = -8'sd1;
            end
            send_item(ACT_SAMPLE, smp, i[0]);
        end

        // Random phases, each setting the registers and the idle mix
        for (int p = 0; p < PHASES; p++) begin
            drain();
            case (p)
                0: begin thr = 8'd0;   dflt = 8'h80; end
                1: begin thr = 8'd255; dflt = 8'h7F; end
                2: begin thr = 8'd3;   dflt = 8'h00; end
                3: begin thr = 8'd1;   dflt = 8'hFF; end
                default: begin
                    thr  = ($urandom_range(1)) ? 8'($urandom_range(8)) : 8'($urandom_range(255));
                    dflt = 8'($urandom_range(255));
                end
            endcase
            apb_write(REG_THRESHOLD, thr);
            apb_write(REG_DEFAULT, dflt);
            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 52; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 52; end
                default: begin src_idle_pct = 22; sink_stall_pct = 22; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_random_item();
            end
        end

        drain();
        if (errors == 0) begin
            $display("signal_strength_average_deadband_core test passed");
        end else begin
            $display("signal_strength_average_deadband_core test failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(10_000_000);
        $display("signal_strength_average_deadband_core test failed");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/ssad_pkg.sv
hw/rtl/ssad_cell.sv
hw/rtl/ssad_avg.sv
hw/rtl/signal_strength_average_deadband_core.sv
sim/ssad_level_checker.sv
sim/tb_top.sv
